@@ hdl/slt_pkg.sv @@
// ---------------------------------------------------------------------------
// slt_pkg: shared types and constants of the sorted list table
// Table sizes, command and status codes, and the structs between the
// table control and its row of storage cells.
// ---------------------------------------------------------------------------
package slt_pkg;

   // table geometry
   localparam int DEPTH     = 16;
   localparam int KEY_WIDTH = 32;
   localparam int CNT_W     = $clog2(DEPTH + 1);

   // fixed field widths of the ports
   localparam int CMD_W    = 2;
   localparam int POS_W    = 4;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 5;

   // width used to compare a read position against the fill count
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_MISSING = 2'd2,
      ST_RANGE   = 2'd3
   } status_type;

   // broadcast to every cell
   typedef struct packed {
      logic                 ins_en;
      logic                 del_en;
      logic                 descending;
      logic [KEY_WIDTH-1:0] key;
   } cell_ctrl_type;

   // handed from cell to cell: an earlier cell took the insert / the delete
   typedef struct packed {
      logic ins_done;
      logic del_done;
   } cell_chain_type;

endpackage

@@ hdl/slt_cell.sv @@
// ---------------------------------------------------------------------------
// slt_cell: one slot of the sorted list table
// Holds one key. On insert it keeps its key, takes the new key, or takes
// its left neighbor's key; on delete it keeps its key or takes the right
// neighbor's key. Decisions ripple along the row through the chain beat.
// ---------------------------------------------------------------------------
module slt_cell
   import slt_pkg::*;
(
   input  logic                 clock,
   input  cell_ctrl_type        ctrl,
   input  logic                 valid,
   input  logic [KEY_WIDTH-1:0] left_value,
   input  logic [KEY_WIDTH-1:0] right_value,
   input  cell_chain_type       chain_in,
   output cell_chain_type       chain_out,
   output logic [KEY_WIDTH-1:0] value
);

   logic [KEY_WIDTH-1:0] value_ff;
   logic [KEY_WIDTH-1:0] value_in;
   logic                 goes_after;
   logic                 match;

   // local compares against the broadcast key
   always_comb begin
      if (ctrl.descending) begin
         goes_after = valid && (ctrl.key < value_ff);
      end else begin
         goes_after = valid && (ctrl.key > value_ff);
      end
      match = valid && (ctrl.key == value_ff);
   end

   // insert lands at the first cell the key does not go after
   assign chain_out.ins_done = chain_in.ins_done || !goes_after;
   assign chain_out.del_done = chain_in.del_done || match;

   // next slot contents
   always_comb begin
      value_in = value_ff;
      if (ctrl.ins_en) begin
         if (chain_in.ins_done) begin
            value_in = left_value;
         end else if (!goes_after) begin
            value_in = ctrl.key;
         end
      end else if (ctrl.del_en) begin
         if (chain_in.del_done || match) begin
            value_in = right_value;
         end
      end
   end

   // key storage, no reset: slots beyond the count are never read
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

@@ hdl/sorted_list_table.sv @@
// ---------------------------------------------------------------------------
// sorted_list_table: sorted priority table of up to DEPTH keys
// Insert in order, delete first equal key, read by position; every result
// carries length, empty flag and head key.
// ---------------------------------------------------------------------------
//
//   channel   direction  handshake           payload
//   req_      in         req_valid/req_stall cmd, key, position
//   rsp_      out        rsp_valid/rsp_stall status, read_value, length,
//                                            is_empty, head_value
//   csr_      in         csr_valid/csr_ready descending_order
//
// One command per cycle: each command is decided in the cycle it is
// accepted by a ripple through the cell row and lands in the result
// register at the end of that cycle. Throughput is one beat per cycle while
// rsp_stall is low; a stalled result holds off the next request.
// Reset (synchronous) empties the table and selects ascending order;
// no clearing pass is needed, the fill count alone marks valid slots.
//
module sorted_list_table
   import slt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic [31:0]          req_key,
   input  logic [POS_W-1:0]     req_position,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [31:0]          rsp_read_value,
   output logic [LEN_W-1:0]     rsp_length,
   output logic                 rsp_is_empty,
   output logic [31:0]          rsp_head_value,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_descending_order
);

   logic                 descending_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   status_type           status_ff;
   status_type           status_in;
   logic [KEY_WIDTH-1:0] read_value_ff;
   logic [KEY_WIDTH-1:0] read_value_in;

   logic                 accept;
   cmd_type              cmd;
   logic                 full;
   logic                 found;
   logic                 in_range;
   logic [KEY_WIDTH-1:0] sel_value;
   cell_ctrl_type        ctrl;

   logic [KEY_WIDTH-1:0] cell_value [DEPTH];
   cell_chain_type       chain [DEPTH+1];

   // handshake
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign cmd       = cmd_type'(req_cmd);

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign found    = chain[DEPTH].del_done;
   assign in_range = (CMP_W'(req_position) < CMP_W'(count_ff));

   // broadcast control to the cell row
   always_comb begin
      ctrl.key        = req_key[KEY_WIDTH-1:0];
      ctrl.descending = descending_ff;
      ctrl.ins_en     = accept && (cmd == CMD_INSERT) && !full;
      ctrl.del_en     = accept && (cmd == CMD_DELETE);
   end

   // row of cells
   assign chain[0] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [KEY_WIDTH-1:0] left_value;
      logic [KEY_WIDTH-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = cell_value[i];
      end else begin : g_mid
         assign left_value = cell_value[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_body
         assign right_value = cell_value[i+1];
      end

      slt_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .valid       (CNT_W'(i) < count_ff),
         .left_value  (left_value),
         .right_value (right_value),
         .chain_in    (chain[i]),
         .chain_out   (chain[i+1]),
         .value       (cell_value[i])
      );
   end

   // read select over the slots
   always_comb begin
      sel_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (CMP_W'(req_position) == CMP_W'(i)) begin
            sel_value = cell_value[i];
         end
      end
   end

   // command decode: status, read data, next count
   always_comb begin
      status_in     = ST_OK;
      read_value_in = '0;
      count_in      = count_ff;
      case (cmd)
         CMD_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_DELETE: begin
            if (found) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               status_in = ST_MISSING;
            end
         end
         CMD_READ: begin
            if (in_range) begin
               read_value_in = sel_value;
            end else begin
               status_in = ST_RANGE;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         descending_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
         if (csr_valid && csr_ready) begin
            descending_ff <= csr_descending_order;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff     <= status_in;
         read_value_ff <= read_value_in;
      end
   end

   // table state holds while a result waits, so length and head come live
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_read_value = 32'(read_value_ff);
   assign rsp_length     = LEN_W'(count_ff);
   assign rsp_is_empty   = (count_ff == '0);
   assign rsp_head_value = (count_ff == '0) ? 32'd0 : 32'(cell_value[0]);

`ifndef SYNTHESIS
   // fill count stays within the table
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count exceeds depth");

   // request side only stalls behind a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("request stalled with no result pending");

   // a successful insert grows the table by one
   a_insert_grow: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd == CMD_INSERT && !full) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the table");

   // a full status only comes from a full table
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> rsp_length == LEN_W'(DEPTH))
      else $error("full status with room left");
`endif

endmodule
